>>> rtl/mcdi_pkg.sv
// ----------------------------------------------------------------------------
// mcdi_pkg
// Shared constants and types for the mesh corner de-duplicating indexer.
// ----------------------------------------------------------------------------
package mcdi_pkg;

  // Number of distinct triples the table can hold.
  localparam int unsigned TableDepth = 4096;
  // Number of significant bits in each index field.
  localparam int unsigned IndexBits  = 20;

  // Fixed width of one index field on the ports.
  localparam int unsigned FieldW = 20;
  localparam int unsigned KeyW   = 3 * FieldW;
  localparam int unsigned AddrW  = $clog2(TableDepth);
  localparam int unsigned CntW   = AddrW + 1;

  typedef logic [FieldW-1:0] field_t;
  typedef logic [KeyW-1:0]   key_t;
  typedef logic [CntW-1:0]   cnt_t;

  // Mask applied to every index field and to the emitted index.
  localparam field_t IdxMask = field_t'((64'd1 << IndexBits) - 64'd1);

  localparam cnt_t DepthCnt = cnt_t'(TableDepth);

endpackage

>>> rtl/mcdi_ram.sv
// ----------------------------------------------------------------------------
// mcdi_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mcdi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/mesh_corner_dedup_indexer.sv
// ----------------------------------------------------------------------------
// mesh_corner_dedup_indexer
// Turns face corners into index buffer entries; with texturing on, it gives
// each distinct (vertex, texture, normal) triple a new index by first use.
// ----------------------------------------------------------------------------
// One corner is taken per input transaction; a triangle corner gives one
// result and the fourth corner of a quad gives three (corners 0, 2 and 3).
// With texturing on, each result is found by a linear search of the triple
// table held in one RAM: each entry is read and then compared in turn,
// over the N triples held (at most TableDepth), and the result then waits
// for the output register to empty.
// With texturing off the result is the vertex index. A new corner is accepted
// only once all results of the previous one are in the output register.
// ----------------------------------------------------------------------------
module mesh_corner_dedup_indexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: bit 0 is use_texture.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // Input corner.
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // From bit 0: vertex_index[19:0], texcoord_index[39:20], normal_index[59:40].
  input  logic [63:0] s_tdata_i,
  // Bit 0: quad_face.
  input  logic        s_tuser_i,
  // Result.
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // From bit 0: out_index[19:0], is_new[20], src_vertex[40:21],
  // src_texcoord[60:41], src_normal[80:61], overflow[81].
  output logic [87:0] m_tdata_o,
  output logic        m_tlast_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_CMP,
    S_MISS,
    S_OUT
  } state_e;

  state_e             state_q;
  logic               use_tex_q;
  logic [1:0]         pos_q;
  logic               multi_q;
  logic [1:0]         k_q;
  mcdi_pkg::key_t     cur_q, saved0_q, saved1_q;
  mcdi_pkg::cnt_t     next_q, srch_q;
  mcdi_pkg::field_t   res_idx_q;
  logic               res_new_q, res_ovf_q;
  logic               out_valid_q, out_last_q;
  logic [87:0]        out_data_q;

  mcdi_pkg::key_t     key_in, key_sel, rd_data;
  logic               ram_we, ram_re, is_last;

  // Masked key of the incoming corner.
  assign key_in = {s_tdata_i[59:40] & mcdi_pkg::IdxMask,
                   s_tdata_i[39:20] & mcdi_pkg::IdxMask,
                   s_tdata_i[19:0]  & mcdi_pkg::IdxMask};

  // Key of the corner now being emitted.
  always_comb begin
    key_sel = cur_q;
    if (multi_q) begin
      case (k_q)
        2'd0:    key_sel = saved0_q;
        2'd1:    key_sel = saved1_q;
        default: key_sel = cur_q;
      endcase
    end
  end

  assign is_last    = !multi_q || (k_q == 2'd2);
  assign s_tready_o = (state_q == S_IDLE);
  assign ram_re     = (state_q == S_RD);
  assign ram_we     = (state_q == S_MISS) && (next_q < mcdi_pkg::DepthCnt);

  mcdi_ram #(
    .Width(mcdi_pkg::KeyW),
    .Depth(mcdi_pkg::TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(next_q[mcdi_pkg::AddrW-1:0]),
    .wdata_i(key_sel),
    .re_i   (ram_re),
    .raddr_i(srch_q[mcdi_pkg::AddrW-1:0]),
    .rdata_o(rd_data)
  );

  // Sequencer, table search and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      use_tex_q   <= 1'b1;
      pos_q       <= 2'd0;
      multi_q     <= 1'b0;
      k_q         <= 2'd0;
      next_q      <= '0;
      srch_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        use_tex_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_tvalid_i) begin
            cur_q   <= key_in;
            k_q     <= 2'd0;
            multi_q <= (pos_q == 2'd3);
            state_q <= S_START;
            case (pos_q)
              2'd0: begin
                saved0_q <= key_in;
                pos_q    <= 2'd1;
              end
              2'd1: pos_q <= 2'd2;
              2'd2: begin
                saved1_q <= key_in;
                pos_q    <= s_tuser_i ? 2'd3 : 2'd0;
              end
              default: pos_q <= 2'd0;
            endcase
          end
        end
        S_START: begin
          srch_q    <= '0;
          res_new_q <= 1'b0;
          res_ovf_q <= 1'b0;
          if (!use_tex_q) begin
            res_idx_q <= key_sel[mcdi_pkg::FieldW-1:0];
            state_q   <= S_OUT;
          end else if (next_q == '0) begin
            state_q <= S_MISS;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (rd_data == key_sel) begin
            res_idx_q <= mcdi_pkg::field_t'(srch_q) & mcdi_pkg::IdxMask;
            state_q   <= S_OUT;
          end else begin
            srch_q  <= srch_q + 1'b1;
            state_q <= (srch_q + 1'b1 >= next_q) ? S_MISS : S_RD;
          end
        end
        S_MISS: begin
          if (next_q < mcdi_pkg::DepthCnt) begin
            res_idx_q <= mcdi_pkg::field_t'(next_q) & mcdi_pkg::IdxMask;
            res_new_q <= 1'b1;
            next_q    <= next_q + 1'b1;
          end else begin
            res_idx_q <= '0;
            res_ovf_q <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_last_q  <= is_last;
            out_data_q  <= {6'b0, res_ovf_q, key_sel, res_new_q, res_idx_q};
            k_q         <= k_q + 2'd1;
            state_q     <= is_last ? S_IDLE : S_START;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // The table never holds more triples than it has entries.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= mcdi_pkg::DepthCnt)
    else $error("triple count beyond table depth");

  // A compare only ever looks at a filled entry.
  a_srch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (srch_q < next_q))
    else $error("search beyond filled entries");

  // A result is never both new and an overflow.
  a_new_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[20] && out_data_q[81]))
    else $error("is_new and overflow both set");

  // The count grows only when a new triple is written.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_q != $past(next_q)) |-> $past(ram_we))
    else $error("triple count changed without a write");
`endif

endmodule
